// File: src/u8dv_pkg.sv
package u8dv_pkg;

    localparam int COUNT_WIDTH_DEFAULT = 16;

    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = 2;
    localparam int OQ_CNT_W = 3;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_LEAD  = 3'd1,
        ST_BAD_CONT  = 3'd2,
        ST_TRUNCATED = 3'd3,
        ST_TERM      = 3'd4
    } status_t;

    typedef struct packed {
        logic [20:0] char_code;
        logic [2:0]  byte_count;
        status_t     status;
        logic [15:0] char_count;
        logic [15:0] error_offset;
        logic        buffer_done;
        logic        run_last;
    } result_t;

endpackage

// File: src/utf8_stream_decoder_validator.sv
// Results go into a four-entry output queue, registered when their byte is accepted.
// Throughput: one byte per cycle while s_tready is high; a byte yields zero, one or
// two results, and s_tready stays high while the queue has room for two.
// Reset (aresetn low at a rising edge) empties the queue, clears all decoding state
// and counts, and sets stop_reg (stop at NUL) to 1.
module utf8_stream_decoder_validator #(
    parameter int COUNT_WIDTH = u8dv_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] in_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,    // [20:0] char_code, [23:21] byte_count,
                                    // [39:24] char_count, [55:40] error_offset
    output logic [3:0]  m_tuser,    // [2:0] status, [3] run_last
    output logic        m_tlast
);

    localparam int EXT_W = COUNT_WIDTH + 16;

    logic                   stop_reg;
    logic [20:0]            partial_reg, partial_next;
    logic [1:0]             pending_reg, pending_next;
    logic [2:0]             seqlen_reg, seqlen_next;
    logic [COUNT_WIDTH-1:0] chars_reg, chars_next;
    logic [COUNT_WIDTH-1:0] bytepos_reg, bytepos_next;
    logic [COUNT_WIDTH-1:0] start_reg, start_next;
    logic                   term_reg, term_next;

    u8dv_pkg::result_t r0, r1, lr;
    logic [1:0]        n_res;
    logic              lead_valid;
    logic              do_lead;
    logic              accept;
    logic              is_cont;
    logic [20:0]       cont_code;

    u8dv_pkg::result_t                oq_mem [u8dv_pkg::OQ_DEPTH];
    logic [u8dv_pkg::OQ_PTR_W-1:0]    wr_ptr_reg, wr_ptr_p1, rd_ptr_reg;
    logic [u8dv_pkg::OQ_CNT_W-1:0]    cnt_reg;
    logic [1:0]                       push_n;
    logic                             pop;
    u8dv_pkg::result_t                head;

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    function automatic logic [15:0] show16(input logic [COUNT_WIDTH-1:0] v);
        logic [EXT_W-1:0] ext;
        ext = EXT_W'(v);
        return (ext > EXT_W'(16'hFFFF)) ? 16'hFFFF : ext[15:0];
    endfunction

    assign accept  = s_tvalid && s_tready;
    assign is_cont = (s_tdata[7:6] == 2'b10);
    assign cont_code = {partial_reg[14:0], s_tdata[5:0]};

    always_comb begin
        partial_next = partial_reg;
        pending_next = pending_reg;
        seqlen_next  = seqlen_reg;
        chars_next   = chars_reg;
        bytepos_next = bytepos_reg;
        start_next   = start_reg;
        term_next    = term_reg;
        r0           = '0;
        r1           = '0;
        lr           = '0;
        n_res        = 2'd0;
        lead_valid   = 1'b0;
        do_lead      = 1'b0;

        if (term_reg) begin
            n_res = 2'd0;
        end else begin
            if (pending_reg != 2'd0) begin
                if (is_cont) begin
                    if (pending_reg == 2'd1) begin
                        chars_next    = sat_inc(chars_reg);
                        r0.char_code  = cont_code;
                        r0.byte_count = seqlen_reg;
                        r0.status     = u8dv_pkg::ST_OK;
                        r0.char_count = show16(chars_next);
                        n_res         = 2'd1;
                        partial_next  = '0;
                        pending_next  = 2'd0;
                        seqlen_next   = '0;
                    end else begin
                        partial_next = cont_code;
                        pending_next = pending_reg - 2'd1;
                        if (s_tlast) begin
                            r0.status       = u8dv_pkg::ST_TRUNCATED;
                            r0.char_count   = show16(chars_reg);
                            r0.error_offset = show16(start_reg);
                            n_res           = 2'd1;
                            partial_next    = '0;
                            pending_next    = 2'd0;
                            seqlen_next     = '0;
                        end
                    end
                end else begin
                    r0.status       = u8dv_pkg::ST_BAD_CONT;
                    r0.char_count   = show16(chars_reg);
                    r0.error_offset = show16(start_reg);
                    n_res           = 2'd1;
                    partial_next    = '0;
                    pending_next    = 2'd0;
                    seqlen_next     = '0;
                    do_lead         = 1'b1;
                end
            end else begin
                do_lead = 1'b1;
            end

            if (do_lead) begin
                if (stop_reg && (s_tdata == 8'h00)) begin
                    term_next      = 1'b1;
                    lr.status      = u8dv_pkg::ST_TERM;
                    lr.char_count  = show16(chars_reg);
                    lr.buffer_done = 1'b1;
                    lead_valid     = 1'b1;
                end else if (!s_tdata[7]) begin
                    chars_next    = sat_inc(chars_reg);
                    lr.char_code  = {13'd0, s_tdata};
                    lr.byte_count = 3'd1;
                    lr.status     = u8dv_pkg::ST_OK;
                    lr.char_count = show16(chars_next);
                    lead_valid    = 1'b1;
                end else if (s_tdata[7:5] == 3'b110 || s_tdata[7:4] == 4'b1110
                             || s_tdata[7:3] == 5'b11110) begin
                    if (s_tdata[7:5] == 3'b110) begin
                        partial_next = {16'd0, s_tdata[4:0]};
                        pending_next = 2'd1;
                        seqlen_next  = 3'd2;
                    end else if (s_tdata[7:4] == 4'b1110) begin
                        partial_next = {17'd0, s_tdata[3:0]};
                        pending_next = 2'd2;
                        seqlen_next  = 3'd3;
                    end else begin
                        partial_next = {18'd0, s_tdata[2:0]};
                        pending_next = 2'd3;
                        seqlen_next  = 3'd4;
                    end
                    start_next = bytepos_reg;
                    if (s_tlast) begin
                        lr.status       = u8dv_pkg::ST_TRUNCATED;
                        lr.char_count   = show16(chars_reg);
                        lr.error_offset = show16(bytepos_reg);
                        lead_valid      = 1'b1;
                        partial_next    = '0;
                        pending_next    = 2'd0;
                        seqlen_next     = '0;
                    end
                end else begin
                    lr.status       = u8dv_pkg::ST_BAD_LEAD;
                    lr.char_count   = show16(chars_reg);
                    lr.error_offset = show16(bytepos_reg);
                    lead_valid      = 1'b1;
                end

                if (lead_valid) begin
                    if (n_res == 2'd1) begin
                        r1    = lr;
                        n_res = 2'd2;
                    end else begin
                        r0    = lr;
                        n_res = 2'd1;
                    end
                end
            end

            bytepos_next = sat_inc(bytepos_reg);

            if (n_res == 2'd2) begin
                r1.run_last = 1'b1;
                if (s_tlast) begin
                    r1.buffer_done = 1'b1;
                end
            end else if (n_res == 2'd1) begin
                r0.run_last = 1'b1;
                if (s_tlast) begin
                    r0.buffer_done = 1'b1;
                end
            end
        end

        if (s_tlast) begin
            partial_next = '0;
            pending_next = 2'd0;
            seqlen_next  = '0;
            chars_next   = '0;
            bytepos_next = '0;
            start_next   = '0;
            term_next    = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stop_reg    <= 1'b1;
            partial_reg <= '0;
            pending_reg <= 2'd0;
            seqlen_reg  <= '0;
            chars_reg   <= '0;
            bytepos_reg <= '0;
            start_reg   <= '0;
            term_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                stop_reg <= cfg_wr_data;
            end
            if (accept) begin
                partial_reg <= partial_next;
                pending_reg <= pending_next;
                seqlen_reg  <= seqlen_next;
                chars_reg   <= chars_next;
                bytepos_reg <= bytepos_next;
                start_reg   <= start_next;
                term_reg    <= term_next;
            end
        end
    end

    assign push_n    = accept ? n_res : 2'd0;
    assign pop       = m_tvalid && m_tready;
    assign wr_ptr_p1 = wr_ptr_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (push_n != 2'd0) begin
            oq_mem[wr_ptr_reg] <= r0;
        end
        if (push_n == 2'd2) begin
            oq_mem[wr_ptr_p1] <= r1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + u8dv_pkg::OQ_PTR_W'(push_n);
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + u8dv_pkg::OQ_CNT_W'(push_n)
                       - u8dv_pkg::OQ_CNT_W'(pop);
        end
    end

    assign head     = oq_mem[rd_ptr_reg];
    assign m_tvalid = (cnt_reg != '0);
    assign s_tready = (cnt_reg <= u8dv_pkg::OQ_CNT_W'(u8dv_pkg::OQ_DEPTH - 2));
    assign m_tdata  = {head.error_offset, head.char_count, head.byte_count, head.char_code};
    assign m_tuser  = {head.run_last, head.status};
    assign m_tlast  = head.buffer_done;

endmodule

// File: src/u8dv_checker.sv
module u8dv_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic [3:0]  m_tuser,
    input logic        m_tlast
);

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("Result beat shown right after reset.");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("Stalled result beat changed.");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[2:0] != u8dv_pkg::ST_OK) |-> (m_tdata[23:0] == 24'd0))
        else $error("Non-ok beat carries a code point or length.");

    a_ok_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[2:0] == u8dv_pkg::ST_OK)
        |-> (m_tdata[23:21] != 3'd0) && (m_tdata[23:21] <= 3'd4))
        else $error("Ok beat has a bad byte count.");

    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tlast || (m_tuser[2:0] == u8dv_pkg::ST_TERM)) |-> m_tuser[3] && m_tlast)
        else $error("Buffer end beat is not the last beat of its byte.");

endmodule

bind utf8_stream_decoder_validator u8dv_checker u_u8dv_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
